FILE: design/dlpd_pkg.sv
// Package for the decimal length-prefix deframer.
// Holds the controller states, command and status structs and the fixed constants.
// Used by dlpd_ctrl, dlpd_dp and decimal_length_prefix_deframer.
`default_nettype none

package dlpd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LIMIT_W    = 64;

    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INCL_PFX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_LIMIT  = 3'd4;

    localparam logic [7:0]         SEPARATOR_RST = 8'd58;
    localparam logic [LIMIT_W-1:0] BUF_LIMIT_RST = '1;

    // Character codes
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_DIGIT  = 3'd1,
        ERR_TOO_LONG   = 3'd2,
        ERR_OVERFLOW   = 3'd3,
        ERR_EMPTY_LEN  = 3'd4,
        ERR_LEAD_ZERO  = 3'd5,
        ERR_OVER_MAX   = 3'd6,
        ERR_OVER_BUF   = 3'd7
    } t_err;

    typedef enum logic [2:0] {
        ST_LENGTH,
        ST_CHECK,
        ST_REPLAY,
        ST_SEP,
        ST_PAYLOAD,
        ST_HALT
    } t_state;

    // Source of the byte loaded into the output register
    typedef enum logic [2:0] {
        OUT_IN_BYTE,
        OUT_STORED,
        OUT_SEPARATOR,
        OUT_ERROR,
        OUT_EMPTY
    } t_out_sel;

    typedef struct packed {
        logic     digit_take;   // shift a digit into the accumulator and the store
        logic     frame_clear;  // clear accumulator, digit count and leading-zero flag
        logic     rem_load;     // remaining payload takes the accumulated length
        logic     rem_dec;
        logic     rd_start;
        logic     rd_next;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
        t_err     out_err;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic is_sep;
        logic is_digit;
        logic count_full;
        logic overflow;
        logic err_empty;
        logic err_lead;
        logic err_max;
        logic err_buf;
        logic incl_prefix;
        logic len_zero;
        logic rd_last;
        logic rem_one;
    } t_status;

endpackage

`default_nettype wire

FILE: design/dlpd_ctrl.sv
// Controller of the decimal length-prefix deframer: frame state machine.
// Issues commands to dlpd_dp from its status; depends on dlpd_pkg.
`default_nettype none

module dlpd_ctrl
    import dlpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LENGTH;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            ST_LENGTH, ST_PAYLOAD: o_s_tready = i_status.slot_free;
            ST_HALT:               o_s_tready = 1'b1;
            default:               o_s_tready = 1'b0;
        endcase
    end

    assign w_take = i_s_tvalid & o_s_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LENGTH: begin
                if (w_take) begin
                    if (i_status.is_sep) begin
                        n_state = ST_CHECK;
                    end else if (!i_status.is_digit || i_status.count_full
                                 || i_status.overflow) begin
                        n_state = ST_HALT;
                    end
                end
            end
            ST_CHECK: begin
                if (i_status.slot_free) begin
                    if (i_status.err_empty || i_status.err_lead || i_status.err_max
                        || i_status.err_buf) begin
                        n_state = ST_HALT;
                    end else if (i_status.incl_prefix) begin
                        n_state = ST_REPLAY;
                    end else if (i_status.len_zero) begin
                        n_state = ST_LENGTH;
                    end else begin
                        n_state = ST_PAYLOAD;
                    end
                end
            end
            ST_REPLAY: begin
                if (i_status.slot_free && i_status.rd_last) begin
                    n_state = ST_SEP;
                end
            end
            ST_SEP: begin
                if (i_status.slot_free) begin
                    n_state = i_status.len_zero ? ST_LENGTH : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                if (w_take && i_status.rem_one) begin
                    n_state = ST_LENGTH;
                end
            end
            ST_HALT: n_state = ST_HALT;
            default: n_state = ST_HALT;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '{
            digit_take:  1'b0,
            frame_clear: 1'b0,
            rem_load:    1'b0,
            rem_dec:     1'b0,
            rd_start:    1'b0,
            rd_next:     1'b0,
            out_load:    1'b0,
            out_sel:     OUT_ERROR,
            out_last:    1'b0,
            out_err:     ERR_NONE
        };
        case (r_state)
            ST_LENGTH: begin
                if (w_take && !i_status.is_sep) begin
                    if (!i_status.is_digit) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = ERR_BAD_DIGIT;
                    end else if (i_status.count_full) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = ERR_TOO_LONG;
                    end else if (i_status.overflow) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = ERR_OVERFLOW;
                    end else begin
                        o_cmd.digit_take = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (i_status.slot_free) begin
                    if (i_status.err_empty) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = ERR_EMPTY_LEN;
                    end else if (i_status.err_lead) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = ERR_LEAD_ZERO;
                    end else if (i_status.err_max) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = ERR_OVER_MAX;
                    end else if (i_status.err_buf) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = ERR_OVER_BUF;
                    end else if (i_status.incl_prefix) begin
                        o_cmd.rd_start = 1'b1;
                    end else if (i_status.len_zero) begin
                        o_cmd.out_load    = 1'b1;
                        o_cmd.out_sel     = OUT_EMPTY;
                        o_cmd.out_last    = 1'b1;
                        o_cmd.frame_clear = 1'b1;
                    end else begin
                        o_cmd.rem_load    = 1'b1;
                        o_cmd.frame_clear = 1'b1;
                    end
                end
            end
            ST_REPLAY: begin
                if (i_status.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_STORED;
                    o_cmd.rd_next  = 1'b1;
                end
            end
            ST_SEP: begin
                if (i_status.slot_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_sel     = OUT_SEPARATOR;
                    o_cmd.out_last    = i_status.len_zero;
                    o_cmd.frame_clear = 1'b1;
                    o_cmd.rem_load    = !i_status.len_zero;
                end
            end
            ST_PAYLOAD: begin
                if (w_take) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_IN_BYTE;
                    o_cmd.out_last = i_status.rem_one;
                    o_cmd.rem_dec  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/dlpd_dp.sv
// Datapath of the decimal length-prefix deframer: configuration registers, length
// accumulator, digit store, payload counter and output register. Depends on dlpd_pkg.
`default_nettype none

module dlpd_dp
    import dlpd_pkg::*;
#(
    parameter int MAX_DIGITS   = 20,
    parameter int LENGTH_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [7:0]            i_in_byte,
    input  wire logic                  i_m_tready,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_out_valid,
    output logic [7:0]                 o_out_byte,
    output logic                       o_out_last,
    output logic                       o_out_empty,
    output logic [2:0]                 o_out_err
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PW = LENGTH_WIDTH + 4;

    // Configuration
    logic [7:0]         r_sep;
    logic               r_incl;
    logic               r_max_en;
    logic [LIMIT_W-1:0] r_max_len;
    logic [LIMIT_W-1:0] r_buf_limit;

    // Frame state
    logic [LENGTH_WIDTH-1:0] r_acc;
    logic [CW-1:0]           r_count;
    logic                    r_first_zero;
    logic [LENGTH_WIDTH-1:0] r_rem;

    logic [7:0]    r_store [MAX_DIGITS];
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] w_rd_addr;
    logic [7:0]    r_rd_data;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_empty;
    logic [2:0]    r_out_err;

    logic [3:0]         w_digit;
    logic               w_is_digit;
    logic [PW-1:0]      w_product;
    logic [LIMIT_W:0]   w_frame_total;
    logic               w_rd_last;
    logic [7:0]         w_out_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep       <= SEPARATOR_RST;
            r_incl      <= 1'b0;
            r_max_en    <= 1'b0;
            r_max_len   <= '0;
            r_buf_limit <= BUF_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEPARATOR: r_sep       <= i_cfg_data[7:0];
                REG_INCL_PFX:  r_incl      <= i_cfg_data[0];
                REG_MAX_EN:    r_max_en    <= i_cfg_data[0];
                REG_MAX_LEN:   r_max_len   <= i_cfg_data[LIMIT_W-1:0];
                REG_BUF_LIMIT: r_buf_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_is_digit = (i_in_byte inside {[CH_ZERO:CH_NINE]});
    end

    assign w_digit = 4'(i_in_byte - CH_ZERO);

    // acc * 10 + digit in four spare bits; any of them set means the length overflows.
    assign w_product = PW'({r_acc, 3'b000}) + PW'({r_acc, 1'b0}) + PW'(w_digit);

    // Whole frame: payload plus digits plus separator, one bit wider than the limit.
    assign w_frame_total = (LIMIT_W + 1)'(r_acc) + (LIMIT_W + 1)'(r_count)
                           + (LIMIT_W + 1)'(1);

    assign w_rd_last = ((CW + 1)'(r_rd_idx) + (CW + 1)'(1)) == (CW + 1)'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_count      <= '0;
            r_first_zero <= 1'b0;
            r_rem        <= '0;
        end else begin
            if (i_cmd.digit_take) begin
                r_acc   <= w_product[LENGTH_WIDTH-1:0];
                r_count <= r_count + CW'(1);
                if (r_count == '0) begin
                    r_first_zero <= (w_digit == 4'd0);
                end
            end else if (i_cmd.frame_clear) begin
                r_acc        <= '0;
                r_count      <= '0;
                r_first_zero <= 1'b0;
            end
            if (i_cmd.rem_load) begin
                r_rem <= r_acc;
            end else if (i_cmd.rem_dec) begin
                r_rem <= r_rem - LENGTH_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.digit_take) begin
            r_store[r_count[IW-1:0]] <= i_in_byte;
        end
    end

    always_comb begin
        if (i_cmd.rd_start) begin
            w_rd_addr = '0;
        end else if (i_cmd.rd_next && !w_rd_last) begin
            w_rd_addr = r_rd_idx + IW'(1);
        end else begin
            w_rd_addr = r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else begin
            r_rd_idx <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[w_rd_addr];
    end

    always_comb begin
        case (i_cmd.out_sel)
            OUT_IN_BYTE:   w_out_byte = i_in_byte;
            OUT_STORED:    w_out_byte = r_rd_data;
            OUT_SEPARATOR: w_out_byte = r_sep;
            default:       w_out_byte = 8'd0;
        endcase
    end

    // Output register: a new result may load in the cycle the held one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte  <= w_out_byte;
            r_out_last  <= i_cmd.out_last;
            r_out_empty <= (i_cmd.out_sel == OUT_EMPTY);
            r_out_err   <= i_cmd.out_err;
        end
    end

    always_comb begin
        o_status.slot_free   = !r_out_valid || i_m_tready;
        o_status.is_sep      = (i_in_byte == r_sep);
        o_status.is_digit    = w_is_digit;
        o_status.count_full  = (r_count == CW'(MAX_DIGITS));
        o_status.overflow    = |w_product[PW-1:LENGTH_WIDTH];
        o_status.err_empty   = (r_count == '0);
        o_status.err_lead    = (r_count > CW'(1)) && r_first_zero;
        o_status.err_max     = r_max_en && (LIMIT_W'(r_acc) > r_max_len);
        o_status.err_buf     = w_frame_total > {1'b0, r_buf_limit};
        o_status.incl_prefix = r_incl;
        o_status.len_zero    = (r_acc == '0);
        o_status.rd_last     = w_rd_last;
        o_status.rem_one     = (r_rem == LENGTH_WIDTH'(1));
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_empty = r_out_empty;
    assign o_out_err   = r_out_err;

endmodule

`default_nettype wire

FILE: design/decimal_length_prefix_deframer.sv
// Top level of the decimal length-prefix deframer: joins controller and datapath.
// Depends on dlpd_pkg, dlpd_ctrl and dlpd_dp.
//
//  Channel     Direction  Payload
//  s stream    in         tdata[7:0] in_byte
//  m stream    out        tdata[7:0] out_byte; tlast last_of_message;
//                         tuser[0] empty_message, tuser[3:1] error_code
//  cfg write   in         idx 0 separator, 1 include prefix, 2 max enable,
//                         3 max payload length, 4 buffer limit
//
// Length digits and payload bytes are taken at one per cycle while the output register
// has room. The frame checks follow the separator in the check state; with the prefix
// enabled the stored digits leave at one per cycle from the digit store as room allows,
// then the separator, with no input taken. Reset is synchronous, active low, and needs
// no clearing pass. Input is held off while the output register is full and not taken.
`default_nettype none

module decimal_length_prefix_deframer
    import dlpd_pkg::*;
#(
    parameter int MAX_DIGITS   = 20,
    parameter int LENGTH_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] in_byte
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [7:0]                 o_m_tdata,   // [7:0] out_byte
    output logic                       o_m_tlast,
    output logic [3:0]                 o_m_tuser    // [0] empty_message, [3:1] error_code
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_empty;
    logic [2:0] w_err;

    dlpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dlpd_dp #(
        .MAX_DIGITS   (MAX_DIGITS),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_m_tvalid),
        .o_out_byte  (o_m_tdata),
        .o_out_last  (o_m_tlast),
        .o_out_empty (w_empty),
        .o_out_err   (w_err)
    );

    assign o_m_tuser = {w_err, w_empty};

endmodule

`default_nettype wire
